>>> rtl/rgpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgpg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS = 8;
  localparam int COLOR_BITS = 24;
  localparam int CHAN_BITS = 8;
  localparam int NUM_CHAN = 3;
  localparam int DIV_STAGES = 8;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  localparam int WIDTH_RESET = 800;
  localparam int HEIGHT_RESET = 600;
  localparam logic [COLOR_BITS-1:0] START_RESET = 24'hFFFFFF;
  localparam logic [COLOR_BITS-1:0] END_RESET = 24'h000000;
  localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'hFF;
  localparam logic [CHAN_BITS-1:0] CHAN_MIN = 8'h00;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_ORIGIN_X     = 3'd2,
    REG_ORIGIN_Y     = 3'd3,
    REG_START_COLOR  = 3'd4,
    REG_END_COLOR    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic full;
  } fifo_ctl_t;

endpackage

`default_nettype wire

>>> rtl/rgpg_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module rgpg_isqrt #(
  parameter int RW = 22
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_q  [RW];

  // one result bit per stage
  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] rad_in;
    logic [RW+1:0]   sh;
    logic [RW+1:0]   tr;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_rest
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    assign sh = {rem_in[RW-1:0], rad_in[2*RW-1:2*RW-2]};
    assign tr = {root_in, 2'b01};
    assign ge = (sh >= tr);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= ge ? (sh - tr) : sh;
        root_q[s] <= {root_in[RW-2:0], ge};
        rad_q[s]  <= {rad_in[2*RW-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

`default_nettype wire

>>> rtl/rgpg_chan.sv
`timescale 1ns / 1ps
`default_nettype none

module rgpg_chan #(
  parameter int RW = 22
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           vin,
  input  logic [RW-1:0]                  d,
  input  logic [RW-1:0]                  big_d,
  input  logic [rgpg_pkg::COLOR_BITS-1:0] start_color,
  input  logic [rgpg_pkg::COLOR_BITS-1:0] end_color,
  output logic                           vout,
  output logic [rgpg_pkg::COLOR_BITS-1:0] color
);

  import rgpg_pkg::*;

  localparam int VW = RW + 11;
  localparam int QW = RW + 9;
  localparam int LAT = 3 + DIV_STAGES;

  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], vin};
    end
  end

  assign vout = vld[LAT-1];

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
    logic [CHAN_BITS-1:0]   s_c;
    logic [CHAN_BITS-1:0]   e_c;
    logic signed [8:0]      diff;
    logic signed [RW:0]     ds;

    logic [RW+7:0]          p1;
    logic signed [RW+9:0]   p2;
    logic [CHAN_BITS-1:0]   s1;
    logic [RW-1:0]          dd1;
    logic                   dz1;

    logic signed [VW-1:0]   v2;
    logic [CHAN_BITS-1:0]   s2;
    logic [RW-1:0]          dd2;
    logic                   dz2;

    logic                   vpos;
    logic [VW-1:0]          nn;
    logic [RW:0]            ddd;
    logic [QW-1:0]          lim;
    logic                   sat;

    logic [QW-1:0]          rem_q  [DIV_STAGES];
    logic [RW:0]            dv_q   [DIV_STAGES];
    logic [CHAN_BITS-1:0]   q_q    [DIV_STAGES+1];
    logic                   ovr_q  [DIV_STAGES+1];
    logic [CHAN_BITS-1:0]   oval_q [DIV_STAGES+1];

    assign s_c  = start_color[CHAN_BITS*k +: CHAN_BITS];
    assign e_c  = end_color[CHAN_BITS*k +: CHAN_BITS];
    assign diff = $signed({1'b0, e_c}) - $signed({1'b0, s_c});
    assign ds   = $signed({1'b0, d});

    always_ff @(posedge clk) begin
      if (en) begin
        p1  <= s_c * big_d;
        p2  <= diff * ds;
        s1  <= s_c;
        dd1 <= big_d;
        dz1 <= (big_d == '0);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v2  <= $signed(VW'(p1)) + VW'(p2);
        s2  <= s1;
        dd2 <= dd1;
        dz2 <= dz1;
      end
    end

    // rounded quotient numerator 2v + D over divisor 2D
    assign vpos = !v2[VW-1] && (v2 != '0);
    assign nn   = {v2[VW-2:0], 1'b0} + VW'(dd2);
    assign ddd  = {dd2, 1'b0};
    assign lim  = {ddd, 8'b0};
    assign sat  = (nn >= VW'(lim));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[0] <= nn[QW-1:0];
        dv_q[0]  <= ddd;
        q_q[0]   <= '0;
        priority if (dz2) begin
          ovr_q[0]  <= 1'b1;
          oval_q[0] <= s2;
        end else if (!vpos) begin
          ovr_q[0]  <= 1'b1;
          oval_q[0] <= CHAN_MIN;
        end else if (sat) begin
          ovr_q[0]  <= 1'b1;
          oval_q[0] <= CHAN_MAX;
        end else begin
          ovr_q[0]  <= 1'b0;
          oval_q[0] <= CHAN_MIN;
        end
      end
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      logic [QW-1:0] t;
      logic          ge;

      assign t  = {8'b0, dv_q[j]} << (DIV_STAGES - 1 - j);
      assign ge = (rem_q[j] >= t);

      always_ff @(posedge clk) begin
        if (en) begin
          q_q[j+1]    <= {q_q[j][CHAN_BITS-2:0], ge};
          ovr_q[j+1]  <= ovr_q[j];
          oval_q[j+1] <= oval_q[j];
        end
      end

      if (j < DIV_STAGES - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_q[j+1] <= ge ? (rem_q[j] - t) : rem_q[j];
            dv_q[j+1]  <= dv_q[j];
          end
        end
      end
    end

    assign color[CHAN_BITS*k +: CHAN_BITS] =
      ovr_q[DIV_STAGES] ? oval_q[DIV_STAGES] : q_q[DIV_STAGES];
  end

endmodule

`default_nettype wire

>>> rtl/rgpg_ofifo.sv
`timescale 1ns / 1ps
`default_nettype none

module rgpg_ofifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic [rgpg_pkg::COLOR_BITS-1:0] din,
  output rgpg_pkg::fifo_ctl_t             ctl,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rgpg_pkg::COLOR_BITS-1:0] m_tdata
);

  import rgpg_pkg::*;

  logic [COLOR_BITS-1:0] mem [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  pop;
  logic                  full;

  assign pop      = m_tvalid && m_tready;
  assign full     = (count == 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = mem[rd_ptr];
  assign ctl.full = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output buffer count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full output buffer");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("output buffer count did not advance");

endmodule

`default_nettype wire

>>> rtl/radial_gradient_pixel_generator.sv
// radial gradient pixel generator
// slave stream s_* takes one pixel transaction: s_tdata holds pixel_x in the
// low COORD_BITS bits and pixel_y above it. master stream m_* gives one
// transaction per pixel: blue [7:0], green [15:8], red [23:16].
// the apb port holds image size, origin and the two end colors; write it
// only while no pixel is in flight.
// throughput: one pixel per cycle while the output buffer is not full, set
// by a fully pipelined datapath with one square root bit and one quotient
// bit per stage. the datapath runs through three front stages,
// COORD_BITS+10 square root stages, three product stages, eight divide
// stages and one output buffer.
// a two-entry output buffer lets new pixels enter while a result waits;
// once it is full the whole pipeline holds and s_tready drops, nothing is
// lost or repeated.
// synchronous reset clears all valid bits and loads register defaults:
// 800x600, origin 0,0, white to black.
`timescale 1ns / 1ps
`default_nettype none

module radial_gradient_pixel_generator #(
  parameter int COORD_BITS = rgpg_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // pixel_x, pixel_y
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
  // blue, green, red
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [rgpg_pkg::COLOR_BITS-1:0]      m_tdata,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rgpg_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [rgpg_pkg::DATA_BITS-1:0]       pwdata,
  output logic [rgpg_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready
);

  import rgpg_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int SW = C + 1;
  localparam int RW = C + 2 + FRAC_BITS;
  localparam int FL = 3 + RW;

  logic [SW-1:0]         image_width;
  logic [SW-1:0]         image_height;
  logic [C-1:0]          origin_x;
  logic [C-1:0]          origin_y;
  logic [COLOR_BITS-1:0] start_color;
  logic [COLOR_BITS-1:0] end_color;

  logic     wr_en;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SW'(WIDTH_RESET);
      image_height <= SW'(HEIGHT_RESET);
      origin_x     <= '0;
      origin_y     <= '0;
      start_color  <= START_RESET;
      end_color    <= END_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[SW-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[SW-1:0];
        REG_ORIGIN_X:     origin_x     <= pwdata[C-1:0];
        REG_ORIGIN_Y:     origin_y     <= pwdata[C-1:0];
        REG_START_COLOR:  start_color  <= pwdata[COLOR_BITS-1:0];
        REG_END_COLOR:    end_color    <= pwdata[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = DATA_BITS'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_BITS'(image_height);
      REG_ORIGIN_X:     prdata = DATA_BITS'(origin_x);
      REG_ORIGIN_Y:     prdata = DATA_BITS'(origin_y);
      REG_START_COLOR:  prdata = DATA_BITS'(start_color);
      REG_END_COLOR:    prdata = DATA_BITS'(end_color);
      default:          prdata = '0;
    endcase
  end

  fifo_ctl_t fctl;
  logic      en;
  logic      chan_v;
  logic [COLOR_BITS-1:0] chan_color;

  assign en       = !fctl.full;
  assign s_tready = en;

  // front valid chain: offsets, squares, radicand, square root
  logic [FL-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FL-2:0], s_tvalid};
    end
  end

  logic [C-1:0]        px;
  logic [C-1:0]        py;
  logic signed [C:0]   dx;
  logic signed [C:0]   dy;
  logic signed [C+1:0] fxs;
  logic signed [C+1:0] fys;
  logic signed [C+1:0] fxv;
  logic signed [C+1:0] fyv;
  logic [C+1:0]        fxa;
  logic [C+1:0]        fya;

  assign px  = s_tdata[C-1:0];
  assign py  = s_tdata[2*C-1:C];
  assign dx  = $signed({1'b0, px}) - $signed({1'b0, origin_x});
  assign dy  = $signed({1'b0, py}) - $signed({1'b0, origin_y});
  assign fxs = $signed({1'b0, image_width}) - $signed((C+2)'(1))
             - $signed({2'b0, origin_x});
  assign fys = $signed({1'b0, image_height}) - $signed((C+2)'(1))
             - $signed({2'b0, origin_y});
  assign fxv = ({origin_x, 1'b0} <= image_width)  ? fxs : $signed({2'b0, origin_x});
  assign fyv = ({origin_y, 1'b0} <= image_height) ? fys : $signed({2'b0, origin_y});
  assign fxa = fxv[C+1] ? (C+2)'(-fxv) : (C+2)'(fxv);
  assign fya = fyv[C+1] ? (C+2)'(-fyv) : (C+2)'(fyv);

  logic [SW-1:0] ax1, ay1, fx1, fy1;

  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= dx[C] ? SW'(-dx) : SW'(dx);
      ay1 <= dy[C] ? SW'(-dy) : SW'(dy);
      fx1 <= fxa[SW-1:0];
      fy1 <= fya[SW-1:0];
    end
  end

  logic [2*SW-1:0] sqx, sqy, sqfx, sqfy;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx  <= ax1 * ax1;
      sqy  <= ay1 * ay1;
      sqfx <= fx1 * fx1;
      sqfy <= fy1 * fy1;
    end
  end

  logic [2*RW-1:0] rad_d, rad_big;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_d   <= {1'b0, (2*SW+1)'(sqx) + (2*SW+1)'(sqy), (2*FRAC_BITS)'(0)};
      rad_big <= {1'b0, (2*SW+1)'(sqfx) + (2*SW+1)'(sqfy), (2*FRAC_BITS)'(0)};
    end
  end

  logic [RW-1:0] d, big_d;

  rgpg_isqrt #(.RW(RW)) u_sqrt_d (
    .clk  (clk),
    .en   (en),
    .rad  (rad_d),
    .root (d)
  );

  rgpg_isqrt #(.RW(RW)) u_sqrt_big (
    .clk  (clk),
    .en   (en),
    .rad  (rad_big),
    .root (big_d)
  );

  rgpg_chan #(.RW(RW)) u_chan (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .vin         (vld[FL-1]),
    .d           (d),
    .big_d       (big_d),
    .start_color (start_color),
    .end_color   (end_color),
    .vout        (chan_v),
    .color       (chan_color)
  );

  rgpg_ofifo u_ofifo (
    .clk      (clk),
    .rst      (rst),
    .push     (chan_v && en),
    .din      (chan_color),
    .ctl      (fctl),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
